/* rtl/core/tzpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tzpc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MARGIN     = 2'd0;
  localparam logic [1:0] CFG_CAL_SAMPLES = 2'd1;
  localparam logic [1:0] CFG_DFLT_BASE  = 2'd2;
  localparam logic [1:0] CFG_EVENT_LIMIT = 2'd3;

  // Register reset values
  localparam logic [11:0] MARGIN_RST      = 12'd300;
  localparam logic [5:0]  CAL_SAMPLES_RST = 6'd20;
  localparam logic [15:0] DFLT_BASE_RST   = 16'd4000;
  localparam logic [7:0]  EVENT_LIMIT_RST = 8'd50;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_IN    = 2'd1,
    EV_OUT   = 2'd2,
    EV_UNDIR = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [11:0] margin;
    logic [5:0]  cal_samples;
    logic [15:0] dflt_base;
    logic [7:0]  event_limit;
  } cfg_t;

  // One reading after the front stage; lhs = distance + margin
  typedef struct packed {
    logic        zone;
    logic        range_valid;
    logic [16:0] lhs;
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/tzpc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tzpc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tzpc_pkg::cfg_t   cfg,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [15:0]      in_tdata,
  input  wire logic [1:0]       in_tuser,
  output logic                  push,
  output tzpc_pkg::item_t       push_item,
  input  wire logic             q_ready
);

  logic            vld_r;
  logic            vld_nxt;
  tzpc_pkg::item_t item_r;

  // Stage empties when the queue takes its beat and no new beat is accepted
  assign push      = vld_r & q_ready;
  assign push_item = item_r;
  assign in_tready = ~vld_r | q_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tvalid && in_tready) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Classify: split sideband, precompute distance plus margin
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.zone        <= in_tuser[0];
      item_r.range_valid <= in_tuser[1];
      item_r.lhs         <= {1'b0, in_tdata} + {5'd0, cfg.margin};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tzpc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tzpc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tzpc_pkg::item_t push_item,
  output logic                 q_ready,
  input  wire logic            pop,
  output logic                 q_valid,
  output tzpc_pkg::item_t      q_item
);

  // Two-entry queue
  tzpc_pkg::item_t mem_r [2];
  logic            wr_ptr_r;
  logic            wr_ptr_nxt;
  logic            rd_ptr_r;
  logic            rd_ptr_nxt;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;

  assign q_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tzpc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tzpc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tzpc_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire tzpc_pkg::item_t q_item,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [31:0]          out_tdata,
  output logic [1:0]           out_tuser
);

  // Counter state
  logic [5:0]  sample_cnt_r [2];
  logic [5:0]  sample_cnt_nxt [2];
  logic [5:0]  valid_cnt_r [2];
  logic [5:0]  valid_cnt_nxt [2];
  logic [21:0] valid_sum_r [2];
  logic [21:0] valid_sum_nxt [2];
  logic        left_occ_r;
  logic        left_occ_nxt;
  logic [1:0]  order_len_r;
  logic [1:0]  order_len_nxt;
  logic        first_zone_r;
  logic        first_zone_nxt;
  logic [7:0]  in_total_r;
  logic [7:0]  in_total_nxt;
  logic [7:0]  out_total_r;
  logic [7:0]  out_total_nxt;
  logic [7:0]  events_r;
  logic [7:0]  events_nxt;

  // Output register
  logic                  out_vld_r;
  logic                  out_vld_nxt;
  tzpc_pkg::event_kind_t kind_r;
  logic                  occ_out_r;
  logic                  calib_out_r;
  logic                  fin_out_r;
  logic [7:0]            in_out_r;
  logic [7:0]            out_out_r;
  logic [7:0]            ev_out_r;

  // Per-item decode
  logic                  z;
  logic                  active;
  logic                  zone_cal;
  logic                  any_cal;
  logic [5:0]            vc;
  logic [22:0]           prod;
  logic                  blocked;
  logic                  occ;
  tzpc_pkg::event_kind_t kind;
  logic                  calib_after;
  logic                  fin_after;

  assign pop = q_valid & (~out_vld_r | out_tready);

  assign z        = q_item.zone;
  assign active   = events_r < cfg.event_limit;
  assign zone_cal = sample_cnt_r[z] < cfg.cal_samples;
  assign any_cal  = (sample_cnt_r[0] < cfg.cal_samples) |
                    (sample_cnt_r[1] < cfg.cal_samples);
  assign vc       = valid_cnt_r[z];
  assign prod     = {6'd0, q_item.lhs} * {17'd0, vc};
  assign blocked  = (vc == 6'd0) ? (q_item.lhs < {1'b0, cfg.dflt_base})
                                 : (prod < {1'b0, valid_sum_r[z]});

  // State update for the item at the queue head
  always_comb begin
    sample_cnt_nxt = sample_cnt_r;
    valid_cnt_nxt  = valid_cnt_r;
    valid_sum_nxt  = valid_sum_r;
    left_occ_nxt   = left_occ_r;
    order_len_nxt  = order_len_r;
    first_zone_nxt = first_zone_r;
    in_total_nxt   = in_total_r;
    out_total_nxt  = out_total_r;
    events_nxt     = events_r;
    occ            = 1'b0;
    kind           = tzpc_pkg::EV_NONE;
    if (active) begin
      if (zone_cal) begin
        // learning the empty-floor baseline
        sample_cnt_nxt[z] = sample_cnt_r[z] + 6'd1;
        if (q_item.range_valid) begin
          valid_cnt_nxt[z] = valid_cnt_r[z] + 6'd1;
          valid_sum_nxt[z] = valid_sum_r[z] + {5'd0, q_item.lhs} -
                             {10'd0, cfg.margin};
        end
      end else if (!any_cal) begin
        occ = q_item.range_valid & blocked;
        if (occ && (order_len_r < 2'd2) &&
            ((order_len_r == 2'd0) || (first_zone_r != z))) begin
          if (order_len_r == 2'd0) begin
            first_zone_nxt = z;
          end
          order_len_nxt = order_len_r + 2'd1;
        end
        if (!z) begin
          left_occ_nxt = occ;
        end else if (!left_occ_r && !occ && (order_len_nxt != 2'd0)) begin
          if ((order_len_nxt == 2'd2) && !first_zone_nxt) begin
            in_total_nxt = in_total_r + 8'd1;
            kind         = tzpc_pkg::EV_IN;
          end else if (order_len_nxt == 2'd2) begin
            out_total_nxt = out_total_r + 8'd1;
            kind          = tzpc_pkg::EV_OUT;
          end else begin
            kind = tzpc_pkg::EV_UNDIR;
          end
          events_nxt    = events_r + 8'd1;
          order_len_nxt = 2'd0;
        end
      end
    end
    calib_after = (sample_cnt_nxt[0] < cfg.cal_samples) |
                  (sample_cnt_nxt[1] < cfg.cal_samples);
    fin_after   = events_nxt >= cfg.event_limit;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (pop) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r <= '{default: 6'd0};
      valid_cnt_r  <= '{default: 6'd0};
      valid_sum_r  <= '{default: 22'd0};
      left_occ_r   <= 1'b0;
      order_len_r  <= 2'd0;
      first_zone_r <= 1'b0;
      in_total_r   <= 8'd0;
      out_total_r  <= 8'd0;
      events_r     <= 8'd0;
      out_vld_r    <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (pop) begin
        sample_cnt_r <= sample_cnt_nxt;
        valid_cnt_r  <= valid_cnt_nxt;
        valid_sum_r  <= valid_sum_nxt;
        left_occ_r   <= left_occ_nxt;
        order_len_r  <= order_len_nxt;
        first_zone_r <= first_zone_nxt;
        in_total_r   <= in_total_nxt;
        out_total_r  <= out_total_nxt;
        events_r     <= events_nxt;
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r      <= kind;
      occ_out_r   <= occ;
      calib_out_r <= calib_after;
      fin_out_r   <= fin_after;
      in_out_r    <= in_total_nxt;
      out_out_r   <= out_total_nxt;
      ev_out_r    <= events_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, fin_out_r, calib_out_r, occ_out_r,
                       ev_out_r, out_out_r, in_out_r};
  assign out_tuser  = kind_r;

`ifndef SYNTHESIS
  // An event or a blocked beam is only reported once calibration is over
  a_event_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ((kind_r != tzpc_pkg::EV_NONE) || occ_out_r) |-> !calib_out_r)
    else $error("event or occupancy reported while calibrating");

  // Beam order never records more than two entries
  a_order_len: assert property (@(posedge clk) disable iff (!rst_n)
    order_len_r != 2'd3)
    else $error("order length overflow");

  // Every accepted event bumps the event total by exactly one
  a_event_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (kind != tzpc_pkg::EV_NONE) |=> events_r == $past(events_r) + 8'd1)
    else $error("event total did not advance");
`endif

endmodule

`default_nettype wire

/* rtl/core/two_zone_people_counter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    tdata: distance_mm; tuser: zone, range_valid
// out_      out  out_tvalid/out_tready  tdata: count_in..finished; tuser: event_kind
// cfg_      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One reading per cycle sustained while out_tready is high; a reading passes through the
// front register, the queue and the result register on its way to the result beat.
// The state update (one 17x6 multiply and compare) is combinational in the back end.
// rst_n is synchronous; counters, calibration sums, valid flags, pointers and config registers reset.
// A two-entry queue lets the front keep taking beats while the result stalls.
// cfg_ready is always high; writes take effect on the next cycle.

module two_zone_people_counter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beats
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] distance_mm
  input  wire logic [1:0]  in_tuser,   // [0] zone, [1] range_valid
  // result beats
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] count_in, [15:8] count_out,
                                       // [23:16] event_total, [24] zone_occupied,
                                       // [25] calibrating, [26] finished
  output logic [1:0]       out_tuser,  // [1:0] event_kind
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  tzpc_pkg::cfg_t  cfg_r;
  tzpc_pkg::cfg_t  cfg_nxt;
  logic            push;
  tzpc_pkg::item_t push_item;
  logic            q_ready;
  logic            q_valid;
  tzpc_pkg::item_t q_item;
  logic            pop;

  assign cfg_ready = 1'b1;

  // Register file write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tzpc_pkg::CFG_MARGIN:      cfg_nxt.margin      = cfg_data[11:0];
        tzpc_pkg::CFG_CAL_SAMPLES: cfg_nxt.cal_samples = cfg_data[5:0];
        tzpc_pkg::CFG_DFLT_BASE:   cfg_nxt.dflt_base   = cfg_data;
        tzpc_pkg::CFG_EVENT_LIMIT: cfg_nxt.event_limit = cfg_data[7:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin      <= tzpc_pkg::MARGIN_RST;
      cfg_r.cal_samples <= tzpc_pkg::CAL_SAMPLES_RST;
      cfg_r.dflt_base   <= tzpc_pkg::DFLT_BASE_RST;
      cfg_r.event_limit <= tzpc_pkg::EVENT_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tzpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  tzpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  tzpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned READINGS_TARGET  = 1550;
  localparam int unsigned QUIET_AFTER      = 1350;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  typedef struct {
    bit          zone;
    logic [15:0] dist_mm;
    bit          valid;
  } reading_t;

  typedef struct packed {
    logic [7:0]            n_in;
    logic [7:0]            n_out;
    logic [7:0]            n_events;
    tzpc_pkg::event_kind_t kind;
    logic                  occupied;
    logic                  calibrating;
    logic                  finished;
  } tally_t;

  // shapes of traffic through the doorway
  typedef enum int {WALK_IN, WALK_OUT, PEEK_LEFT, PEEK_RIGHT, STRAY} walk_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] distance_mm
  logic [1:0]  in_tuser = '0;   // [0] zone, [1] range_valid
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [7:0] count_in, [15:8] count_out, [23:16] event_total,
                                // [24] zone_occupied, [25] calibrating, [26] finished
  logic [1:0]  out_tuser;       // [1:0] event_kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = tzpc_pkg::CFG_MARGIN;
  logic [15:0] cfg_data = '0;

  two_zone_people_counter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Counter model state
  tzpc_pkg::cfg_t regs;
  logic [5:0]  cal_seen [2];
  logic [5:0]  cal_good [2];
  logic [21:0] cal_sum [2];
  logic        left_blocked;
  logic [1:0]  order_len;
  logic        lead_zone;
  logic [7:0]  n_in;
  logic [7:0]  n_out;
  logic [7:0]  n_events;

  reading_t    pending[$];
  tally_t      due_tallies[$];
  int unsigned readings_queued = 0;
  int unsigned tallies_seen = 0;
  int unsigned fail_count = 0;
  int          seg_idx = -1;
  int          beam_edge [2];

  function automatic bit zone_learning(input bit z);
    return cal_seen[z] < regs.cal_samples;
  endfunction

  // exact form of "distance + margin below the mean baseline"
  function automatic bit beam_blocked(input bit z, input logic [15:0] d);
    int unsigned lhs;
    lhs = d + regs.margin;
    if (cal_good[z] == 0) return lhs < regs.dflt_base;
    return lhs * cal_good[z] < cal_sum[z];
  endfunction

  function automatic tally_t count_reading(input reading_t r);
    tally_t t;
    t.kind = tzpc_pkg::EV_NONE;
    t.occupied = 1'b0;
    if (n_events < regs.event_limit) begin
      if (zone_learning(r.zone)) begin
        cal_seen[r.zone]++;
        if (r.valid) begin
          cal_good[r.zone]++;
          cal_sum[r.zone] += r.dist_mm;
        end
      end else if (!zone_learning(0) && !zone_learning(1)) begin
        t.occupied = r.valid && beam_blocked(r.zone, r.dist_mm);
        if (t.occupied && order_len < 2 && (order_len == 0 || lead_zone != r.zone)) begin
          if (order_len == 0) lead_zone = r.zone;
          order_len++;
        end
        // events are only decided on right-beam readings
        if (!r.zone) begin
          left_blocked = t.occupied;
        end else if (!left_blocked && !t.occupied && order_len != 0) begin
          if (order_len == 2 && !lead_zone) begin
            n_in++;
            t.kind = tzpc_pkg::EV_IN;
          end else if (order_len == 2) begin
            n_out++;
            t.kind = tzpc_pkg::EV_OUT;
          end else begin
            t.kind = tzpc_pkg::EV_UNDIR;
          end
          n_events++;
          order_len = 0;
        end
      end
    end
    t.n_in = n_in;
    t.n_out = n_out;
    t.n_events = n_events;
    t.calibrating = zone_learning(0) || zone_learning(1);
    t.finished = n_events >= regs.event_limit;
    return t;
  endfunction

  // first distance that no longer blocks the beam; may be <= 0
  function automatic int clear_from(input bit z);
    int unsigned base;
    int unsigned sum;
    int unsigned cnt;
    sum = cal_sum[z];
    cnt = cal_good[z];
    if (cnt == 0) base = regs.dflt_base;
    else base = (sum + cnt - 1) / cnt;
    return int'(base) - int'(regs.margin);
  endfunction

  function automatic int unsigned gap_pct(input int salt);
    if (tallies_seen >= QUIET_AFTER || (seg_idx + salt + 3) % 3 == 0) return 0;
    return 6;
  endfunction

  function automatic void push_reading(input bit z, input int unsigned d, input bit v);
    reading_t r;
    r.zone = z;
    r.dist_mm = d[15:0];
    r.valid = v;
    pending.push_back(r);
    readings_queued++;
  endfunction

  // one reading that the beam should judge blocked or clear
  function automatic void push_view(input bit z, input bit want_block);
    int lim;
    int lo;
    lim = beam_edge[z];
    lo = (lim < 0) ? 0 : lim;
    if (want_block && lim > 0)
      push_reading(z, ($urandom_range(9) == 0) ? lim - 1 : $urandom_range(lim - 1, 0), 1'b1);
    else if ($urandom_range(4) == 0)
      push_reading(z, $urandom, 1'b0);
    else
      push_reading(z, ($urandom_range(9) == 0) ? lo : $urandom_range(65535, lo), 1'b1);
  endfunction

  function automatic void push_pair(input bit left_block, input bit right_block);
    push_view(1'b0, left_block);
    push_view(1'b1, right_block);
  endfunction

  function automatic void push_walk(input walk_t w);
    int unsigned a;
    int unsigned b;
    int unsigned c;
    a = $urandom_range(4, 1);
    b = $urandom_range(4, 1);
    c = $urandom_range(4, 1);
    case (w)
      WALK_IN: begin
        repeat (a) push_pair(1'b1, 1'b0);
        repeat (b) push_pair(1'b1, 1'b1);
        repeat (c) push_pair(1'b0, 1'b1);
      end
      WALK_OUT: begin
        repeat (a) push_pair(1'b0, 1'b1);
        repeat (b) push_pair(1'b1, 1'b1);
        repeat (c) push_pair(1'b1, 1'b0);
      end
      PEEK_LEFT:  repeat (a) push_pair(1'b1, 1'b0);
      PEEK_RIGHT: repeat (a) push_pair(1'b0, 1'b1);
      default:    repeat (a) push_reading($urandom_range(1), $urandom, $urandom_range(1));
    endcase
    if (w != STRAY) push_pair(1'b0, 1'b0);
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Input driver: predicts each accepted beat, then offers the next reading
  int unsigned src_gap = 0;
  reading_t    on_bus;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_tvalid && in_tready)
        due_tallies.push_back(count_reading(on_bus));
      if (!in_tvalid || in_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (pending.size() != 0 && gap_pct(0) != 0 &&
                     $urandom_range(99) < gap_pct(0)) begin
          src_gap = $urandom_range(18, 0);
          in_tvalid <= 1'b0;
        end else if (pending.size() != 0) begin
          on_bus = pending.pop_front();
          in_tdata <= on_bus.dist_mm;
          in_tuser <= {on_bus.valid, on_bus.zone};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random stalls plus one long hold-off to back up the block
  int unsigned sink_gap = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap = 0;
    end else if (long_hold_left != 0) begin
      long_hold_left--;
      out_tready <= 1'b0;
    end else if (!long_hold_done && seg_idx == 2 && out_tvalid) begin
      long_hold_done = 1'b1;
      long_hold_left = LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      out_tready <= 1'b0;
    end else if (gap_pct(1) != 0 && $urandom_range(99) < gap_pct(1)) begin
      sink_gap = $urandom_range(18, 0);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_check
    tally_t got;
    tally_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.n_in = out_tdata[7:0];
      got.n_out = out_tdata[15:8];
      got.n_events = out_tdata[23:16];
      got.occupied = out_tdata[24];
      got.calibrating = out_tdata[25];
      got.finished = out_tdata[26];
      got.kind = tzpc_pkg::event_kind_t'(out_tuser);
      tallies_seen++;
      if (due_tallies.size() == 0) begin
        $error("result beat with no reading pending");
        fail_count++;
      end else begin
        want = due_tallies.pop_front();
        check_field("count_in", want.n_in, got.n_in);
        check_field("count_out", want.n_out, got.n_out);
        check_field("event_total", want.n_events, got.n_events);
        check_field("event_kind", want.kind, got.kind);
        check_field("zone_occupied", want.occupied, got.occupied);
        check_field("calibrating", want.calibrating, got.calibrating);
        check_field("finished", want.finished, got.finished);
      end
    end
  end

  task automatic wait_idle();
    while (tallies_seen != readings_queued) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tzpc_pkg::CFG_MARGIN:      regs.margin = value[11:0];
      tzpc_pkg::CFG_CAL_SAMPLES: regs.cal_samples = value[5:0];
      tzpc_pkg::CFG_DFLT_BASE:   regs.dflt_base = value[15:0];
      tzpc_pkg::CFG_EVENT_LIMIT: regs.event_limit = value[7:0];
      default: ;
    endcase
  endtask

  // readings around one floor level until both zones have their baseline
  task automatic learn_floor();
    int          left_due;
    int          right_due;
    int unsigned floor_mm;
    bit          z;
    floor_mm = $urandom_range(60000, 3000);
    left_due = int'(regs.cal_samples) - int'(cal_seen[0]);
    right_due = int'(regs.cal_samples) - int'(cal_seen[1]);
    while (left_due > 0 || right_due > 0) begin
      if ($urandom_range(9) == 0) z = $urandom_range(1);
      else if (left_due > 0 && (right_due <= 0 || $urandom_range(1))) z = 1'b0;
      else z = 1'b1;
      if ($urandom_range(6) == 0) push_reading(z, $urandom, 1'b0);
      else push_reading(z, floor_mm + $urandom_range(400) - 200, 1'b1);
      if (z) right_due--;
      else left_due--;
    end
  endtask

  initial begin : stimulus
    int unsigned margin;
    int unsigned samples;
    int unsigned base;
    int unsigned ev_cap;
    int unsigned step;
    int unsigned target;
    int unsigned pick;
    bit          lowered;

    regs.margin = tzpc_pkg::MARGIN_RST;
    regs.cal_samples = tzpc_pkg::CAL_SAMPLES_RST;
    regs.dflt_base = tzpc_pkg::DFLT_BASE_RST;
    regs.event_limit = tzpc_pkg::EVENT_LIMIT_RST;
    for (int z = 0; z < 2; z++) begin
      cal_seen[z] = '0;
      cal_good[z] = '0;
      cal_sum[z] = '0;
    end
    left_blocked = 1'b0;
    order_len = '0;
    lead_zone = 1'b0;
    n_in = '0;
    n_out = '0;
    n_events = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Short calibration, widest margin, stop after one event
    write_reg(tzpc_pkg::CFG_MARGIN, 4000);
    write_reg(tzpc_pkg::CFG_CAL_SAMPLES, 2);
    write_reg(tzpc_pkg::CFG_DFLT_BASE, 65535);
    write_reg(tzpc_pkg::CFG_EVENT_LIMIT, 1);
    push_reading(1'b0, 16'hFFFF, 1'b1);
    push_reading(1'b0, 500, 1'b0);
    push_reading(1'b1, 1234, 1'b0);
    push_reading(1'b0, 0, 1'b1);         // left done, right still learning: ignored
    push_reading(1'b1, 0, 1'b0);         // right ends with no valid reading
    push_reading(1'b0, 0, 1'b1);
    push_reading(1'b1, 61534, 1'b1);     // just inside the default baseline
    push_reading(1'b0, 61535, 1'b1);     // just outside the learned baseline
    push_reading(1'b1, 16'hFFFF, 1'b1);  // in event, then finished
    push_reading(1'b0, 0, 1'b1);         // ignored once finished
    wait_idle();

    // Zero margin, small default baseline: out and undirected events
    write_reg(tzpc_pkg::CFG_MARGIN, 0);
    write_reg(tzpc_pkg::CFG_DFLT_BASE, 5000);
    write_reg(tzpc_pkg::CFG_EVENT_LIMIT, 255);
    push_reading(1'b1, 4999, 1'b1);
    push_reading(1'b0, 65534, 1'b1);
    push_reading(1'b1, 5000, 1'b1);
    push_reading(1'b0, 16'hFFFF, 1'b1);
    push_reading(1'b1, 5000, 1'b0);      // out event
    push_reading(1'b1, 0, 1'b1);
    push_reading(1'b1, 0, 1'b0);         // right beam only
    push_reading(1'b0, 0, 1'b1);
    push_reading(1'b0, 0, 1'b1);         // same beam again does not extend the order
    push_reading(1'b0, 0, 1'b0);
    push_reading(1'b1, 16'hFFFF, 1'b1);  // left beam only
    push_reading(1'b1, 0, 1'b0);
    wait_idle();

    // Random phases, each with its own register setting
    seg_idx = 0;
    while (readings_queued < READINGS_TARGET && seg_idx < 40) begin
      wait_idle();
      if (seg_idx == 0) margin = 0;
      else if (seg_idx == 1) margin = 4000;
      else if ($urandom_range(3) == 0) margin = $urandom_range(1) ? 4000 : 0;
      else margin = $urandom_range(4000);
      case (seg_idx)
        0:       samples = $urandom_range(20, 3);
        1:       samples = 63;
        3:       samples = 1;
        default: samples = $urandom_range(63, 1);
      endcase
      base = (seg_idx % 3 == 0) ? 65535 : $urandom_range(65535);
      lowered = seg_idx == 4 && n_events != 0;
      step = $urandom_range(40, 4);
      if (lowered) ev_cap = $urandom_range(n_events, 1);
      else if (readings_queued >= QUIET_AFTER || n_events + step > 255) ev_cap = 255;
      else ev_cap = n_events + step;
      write_reg(tzpc_pkg::CFG_MARGIN, margin);
      write_reg(tzpc_pkg::CFG_CAL_SAMPLES, samples);
      write_reg(tzpc_pkg::CFG_DFLT_BASE, base);
      write_reg(tzpc_pkg::CFG_EVENT_LIMIT, ev_cap);
      learn_floor();
      wait_idle();

      beam_edge[0] = clear_from(1'b0);
      beam_edge[1] = clear_from(1'b1);
      target = readings_queued + (lowered ? 20 : $urandom_range(300, 150));
      while (readings_queued < target && readings_queued < READINGS_TARGET) begin
        pick = $urandom_range(99);
        if (pick < 30) push_walk(WALK_IN);
        else if (pick < 60) push_walk(WALK_OUT);
        else if (pick < 70) push_walk(PEEK_LEFT);
        else if (pick < 80) push_walk(PEEK_RIGHT);
        else push_walk(STRAY);
      end
      seg_idx++;
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (due_tallies.size() != 0) begin
      $error("%0d expected results never arrived", due_tallies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("two_zone_people_counter regression: pass");
    end else begin
      $display("two_zone_people_counter regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("two_zone_people_counter regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/core/tzpc_pkg.sv
rtl/core/tzpc_front.sv
rtl/core/tzpc_queue.sv
rtl/core/tzpc_back.sv
rtl/core/two_zone_people_counter.sv
tb/tb_top.sv
